### design/eul_pkg.sv
// Shared types, constants and functions of the Euler angle to rotation matrix unit.
package eul_pkg;

   // Default parameter values.
   localparam int ANGLE_WIDTH_DEF = 16;
   localparam int COEF_WIDTH_DEF  = 16;
   localparam int TRIG_STAGES_DEF = 16;

   // CORDIC datapath: 30 fraction bits, two guard bits above the sign.
   localparam int FRAC_BITS = 30;
   localparam int LANE_W    = 34;
   localparam int TRIG_W    = 32;
   localparam logic signed [LANE_W-1:0] CORDIC_X0 = 34'sd652032874;

   // One angle in flight through the CORDIC chain.
   typedef struct packed {
      logic signed [LANE_W-1:0] x;
      logic signed [LANE_W-1:0] y;
      logic signed [LANE_W-1:0] z;
      logic                     neg;
   } lane_type;

   // Roll, pitch and yaw lanes of one request (index 0, 1, 2).
   typedef struct packed {
      logic                 valid;
      lane_type [2:0]       lane;
   } stage_type;

   // Arctangent of 2^-i as a 32-bit binary angle.
   function automatic logic signed [LANE_W-1:0] atan_entry(input int unsigned i);
      logic signed [LANE_W-1:0] t;
      case (i)
         0:  t = 34'sd536870912;
         1:  t = 34'sd316933406;
         2:  t = 34'sd167458907;
         3:  t = 34'sd85004756;
         4:  t = 34'sd42667331;
         5:  t = 34'sd21354465;
         6:  t = 34'sd10679838;
         7:  t = 34'sd5340245;
         8:  t = 34'sd2670163;
         9:  t = 34'sd1335087;
         10: t = 34'sd667544;
         11: t = 34'sd333772;
         12: t = 34'sd166886;
         13: t = 34'sd83443;
         14: t = 34'sd41722;
         15: t = 34'sd20861;
         16: t = 34'sd10430;
         17: t = 34'sd5215;
         18: t = 34'sd2608;
         19: t = 34'sd1304;
         20: t = 34'sd652;
         21: t = 34'sd326;
         22: t = 34'sd163;
         23: t = 34'sd81;
         24: t = 34'sd41;
         25: t = 34'sd20;
         26: t = 34'sd10;
         27: t = 34'sd5;
         28: t = 34'sd3;
         29: t = 34'sd1;
         30: t = 34'sd1;
         default: t = '0;
      endcase
      return t;
   endfunction

   // Fold a 32-bit binary angle into [-pi/2, pi/2) and load the CORDIC start vector.
   function automatic lane_type reduce_angle(input logic [31:0] a);
      lane_type    l;
      logic [31:0] sum;
      logic [31:0] a2;
      sum   = a + 32'h4000_0000;
      l.neg = sum[31];
      a2    = sum[31] ? (a + 32'h8000_0000) : a;
      l.x   = CORDIC_X0;
      l.y   = '0;
      l.z   = LANE_W'(signed'(a2));
      return l;
   endfunction

endpackage

### design/eul_if.sv
// Request and response channel interfaces of the Euler angle to rotation matrix unit.
interface eul_req_if #(parameter int ANGLE_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [ANGLE_WIDTH-1:0] roll_angle;
   logic signed [ANGLE_WIDTH-1:0] pitch_angle;
   logic signed [ANGLE_WIDTH-1:0] yaw_angle;

   modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
   modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface eul_rsp_if #(parameter int COEF_WIDTH = 16);
   logic                         valid;
   logic                         ready;
   logic signed [COEF_WIDTH-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;

   modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   input ready);
   modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   output ready);
endinterface

### design/euler_to_rotation_matrix_unit.sv
// Throughput: one request per cycle; the whole pipeline advances together and holds
// while a finished response waits; the CORDIC cell chain and the matrix stages set the depth.
// Reset: synchronous, active high; clears every stage valid bit, data is not reset.
// The unit keeps no state between requests.
module euler_to_rotation_matrix_unit #(
   parameter int ANGLE_WIDTH = eul_pkg::ANGLE_WIDTH_DEF,
   parameter int COEF_WIDTH  = eul_pkg::COEF_WIDTH_DEF,
   parameter int TRIG_STAGES = eul_pkg::TRIG_STAGES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   eul_req_if.sink   req_bus,
   eul_rsp_if.source rsp_bus
);
   import eul_pkg::*;

   logic      en;
   stage_type pipe [TRIG_STAGES+1];
   logic      out_valid;
   logic signed [COEF_WIDTH-1:0] coef [9];

   // The pipeline moves whenever the output register is empty or being emptied.
   assign en            = !out_valid || rsp_bus.ready;
   assign req_bus.ready = en;

   // Expand each angle to a 32-bit binary angle and fold it into the CORDIC range.
   assign pipe[0].valid   = req_bus.valid;
   assign pipe[0].lane[0] = reduce_angle(32'(unsigned'(req_bus.roll_angle))
                                         << (32 - ANGLE_WIDTH));
   assign pipe[0].lane[1] = reduce_angle(32'(unsigned'(req_bus.pitch_angle))
                                         << (32 - ANGLE_WIDTH));
   assign pipe[0].lane[2] = reduce_angle(32'(unsigned'(req_bus.yaw_angle))
                                         << (32 - ANGLE_WIDTH));

   // Chain of CORDIC cells.
   for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cell
      eul_cordic_cell #(.STAGE(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .stage_in  (pipe[g]),
         .stage_out (pipe[g+1])
      );
   end

   // Products and output register.
   eul_matrix #(.COEF_WIDTH(COEF_WIDTH)) u_matrix (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .trig_in   (pipe[TRIG_STAGES]),
      .out_valid (out_valid),
      .coef      (coef)
   );

   assign rsp_bus.valid = out_valid;
   assign rsp_bus.r00   = coef[0];
   assign rsp_bus.r01   = coef[1];
   assign rsp_bus.r02   = coef[2];
   assign rsp_bus.r10   = coef[3];
   assign rsp_bus.r11   = coef[4];
   assign rsp_bus.r12   = coef[5];
   assign rsp_bus.r20   = coef[6];
   assign rsp_bus.r21   = coef[7];
   assign rsp_bus.r22   = coef[8];

   // An accepted request enters the first cell.
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> pipe[1].valid)
      else $error("accepted request did not enter the cell chain");

   // A stalled pipeline keeps the first cell's valid bit.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> pipe[1].valid == $past(pipe[1].valid))
      else $error("cell chain moved during a stall");

   // No response in the cycle after a reset edge.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("response valid after reset");
endmodule

### design/eul_cordic_cell.sv
// One CORDIC rotation cell, applied to the roll, pitch and yaw lanes together.
module eul_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  eul_pkg::stage_type  stage_in,
   output eul_pkg::stage_type  stage_out
);
   import eul_pkg::*;

   localparam logic signed [LANE_W-1:0] ATAN = atan_entry(STAGE);

   logic           valid_ff;
   lane_type [2:0] lane_ff;
   lane_type [2:0] lane_in;

   // Rotate each lane towards zero residual angle.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lane_in[k].neg = stage_in.lane[k].neg;
         if (!stage_in.lane[k].z[LANE_W-1]) begin
            lane_in[k].x = stage_in.lane[k].x - (stage_in.lane[k].y >>> STAGE);
            lane_in[k].y = stage_in.lane[k].y + (stage_in.lane[k].x >>> STAGE);
            lane_in[k].z = stage_in.lane[k].z - ATAN;
         end else begin
            lane_in[k].x = stage_in.lane[k].x + (stage_in.lane[k].y >>> STAGE);
            lane_in[k].y = stage_in.lane[k].y - (stage_in.lane[k].x >>> STAGE);
            lane_in[k].z = stage_in.lane[k].z + ATAN;
         end
      end
   end

   // Valid bit is reset; the lane data is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
      end
   end

   assign stage_out.valid = valid_ff;
   assign stage_out.lane  = lane_ff;
endmodule

### design/eul_matrix.sv
// Product, sum, rounding and saturation pipeline that forms the nine matrix entries.
module eul_matrix #(
   parameter int COEF_WIDTH = eul_pkg::COEF_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  eul_pkg::stage_type           trig_in,
   output logic                         out_valid,
   output logic signed [COEF_WIDTH-1:0] coef [9]
);
   import eul_pkg::*;

   localparam int SUM_W = 66;
   localparam int SH    = 2 * FRAC_BITS - (COEF_WIDTH - 1);
   localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (SH - 1);
   localparam logic signed [SUM_W-1:0] HI   = (SUM_W'(1) <<< (COEF_WIDTH - 1)) - 1;
   localparam logic signed [SUM_W-1:0] LO   = -(SUM_W'(1) <<< (COEF_WIDTH - 1));
   localparam logic signed [63:0] HALF30    = 64'sd1 <<< (FRAC_BITS - 1);

   // Round half up to the output precision and saturate.
   function automatic logic signed [COEF_WIDTH-1:0] to_coef(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] r;
      r = (v + HALF) >>> SH;
      if (r > HI) begin
         r = HI;
      end else if (r < LO) begin
         r = LO;
      end
      return COEF_WIDTH'(r);
   endfunction

   // Stage 0: undo the half-turn fold and narrow to 32 bits.
   logic                     v0_ff;
   logic signed [TRIG_W-1:0] cs_ff [3];
   logic signed [TRIG_W-1:0] sn_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= trig_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            cs_ff[k] <= TRIG_W'(trig_in.lane[k].neg ? -trig_in.lane[k].x : trig_in.lane[k].x);
            sn_ff[k] <= TRIG_W'(trig_in.lane[k].neg ? -trig_in.lane[k].y : trig_in.lane[k].y);
         end
      end
   end

   // Stage 1: the ten two-factor products.
   logic               v1_ff;
   logic signed [63:0] cpcy_ff, cpsy_ff, srcp_ff, crcp_ff;
   logic signed [63:0] crsy_ff, crcy_ff, srsy_ff, srcy_ff, srsp_ff, crsp_ff;
   logic signed [TRIG_W-1:0] sp1_ff, cy1_ff, sy1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cpcy_ff <= cs_ff[1] * cs_ff[2];
         cpsy_ff <= cs_ff[1] * sn_ff[2];
         srcp_ff <= sn_ff[0] * cs_ff[1];
         crcp_ff <= cs_ff[0] * cs_ff[1];
         crsy_ff <= cs_ff[0] * sn_ff[2];
         crcy_ff <= cs_ff[0] * cs_ff[2];
         srsy_ff <= sn_ff[0] * sn_ff[2];
         srcy_ff <= sn_ff[0] * cs_ff[2];
         srsp_ff <= sn_ff[0] * sn_ff[1];
         crsp_ff <= cs_ff[0] * sn_ff[1];
         sp1_ff  <= sn_ff[1];
         cy1_ff  <= cs_ff[2];
         sy1_ff  <= sn_ff[2];
      end
   end

   // Stage 2: round the roll-pitch products and form the three-factor terms.
   logic signed [63:0]       srsp_rnd, crsp_rnd;
   logic signed [TRIG_W-1:0] srsp_n, crsp_n;

   assign srsp_rnd = (srsp_ff + HALF30) >>> FRAC_BITS;
   assign crsp_rnd = (crsp_ff + HALF30) >>> FRAC_BITS;
   assign srsp_n   = TRIG_W'(srsp_rnd);
   assign crsp_n   = TRIG_W'(crsp_rnd);

   logic               v2_ff;
   logic signed [63:0] a01_ff, a02_ff, a11_ff, a12_ff;
   logic signed [63:0] b00_ff, b10_ff, b21_ff, b22_ff;
   logic signed [63:0] c01_ff, c02_ff, c11_ff, c12_ff;
   logic signed [TRIG_W-1:0] sp2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a01_ff <= srsp_n * cy1_ff;
         a02_ff <= crsp_n * cy1_ff;
         a11_ff <= srsp_n * sy1_ff;
         a12_ff <= crsp_n * sy1_ff;
         c01_ff <= crsy_ff;
         c02_ff <= srsy_ff;
         c11_ff <= crcy_ff;
         c12_ff <= srcy_ff;
         b00_ff <= cpcy_ff;
         b10_ff <= cpsy_ff;
         b21_ff <= srcp_ff;
         b22_ff <= crcp_ff;
         sp2_ff <= sp1_ff;
      end
   end

   // Stage 3: sums, rounding and saturation into the output register.
   logic signed [SUM_W-1:0] sum_in [9];

   always_comb begin
      sum_in[0] = SUM_W'(b00_ff);
      sum_in[1] = SUM_W'(a01_ff) - SUM_W'(c01_ff);
      sum_in[2] = SUM_W'(a02_ff) + SUM_W'(c02_ff);
      sum_in[3] = SUM_W'(b10_ff);
      sum_in[4] = SUM_W'(a11_ff) + SUM_W'(c11_ff);
      sum_in[5] = SUM_W'(a12_ff) - SUM_W'(c12_ff);
      sum_in[6] = -(SUM_W'(sp2_ff) <<< FRAC_BITS);
      sum_in[7] = SUM_W'(b21_ff);
      sum_in[8] = SUM_W'(b22_ff);
   end

   logic                         v3_ff;
   logic signed [COEF_WIDTH-1:0] coef_ff [9];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 9; k++) begin
            coef_ff[k] <= to_coef(sum_in[k]);
         end
      end
   end

   assign out_valid = v3_ff;
   assign coef      = coef_ff;
endmodule

### dv/tb_top.sv
// Self-checking testbench of the Euler angle to rotation matrix unit.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int AW = eul_pkg::ANGLE_WIDTH_DEF;
   localparam int CW = eul_pkg::COEF_WIDTH_DEF;
   localparam int NSTAGE = eul_pkg::TRIG_STAGES_DEF;
   localparam int LATENCY = NSTAGE + 4;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [CW-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
   } matrix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   eul_req_if #(.ANGLE_WIDTH(AW)) req_bus ();
   eul_rsp_if #(.COEF_WIDTH(CW)) rsp_bus ();

   euler_to_rotation_matrix_unit #(
      .ANGLE_WIDTH(AW), .COEF_WIDTH(CW), .TRIG_STAGES(NSTAGE)
   ) dut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source)
   );

   matrix_type expected_matrices[$];
   int      error_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      hold_off_cycles = 0;
   longint  cycle_count = 0;

   // Clock generation.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog on the cycle count.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Rotation-mode CORDIC for one angle: cosine and sine with 30 fraction bits.
   task automatic angle_trig(input logic [AW-1:0] ang, output longint c, output longint s);
      logic [31:0] a;
      logic        flip;
      longint      x, y, z, nx;
      a = {ang, {(32-AW){1'b0}}};
      flip = 1'b0;
      if (((a + 32'h4000_0000) >> 31) & 1) begin
         a = a + 32'h8000_0000;
         flip = 1'b1;
      end
      x = 652032874;
      y = 0;
      z = longint'($signed(a));
      for (int i = 0; i < NSTAGE; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - longint'(eul_pkg::atan_entry(i));
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + longint'(eul_pkg::atan_entry(i));
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   // Round a 60-fraction-bit value to a saturated output coefficient.
   function automatic logic signed [CW-1:0] to_coef(input longint v60);
      longint v;
      longint hi;
      longint lo;
      v = (v60 + (longint'(1) <<< (60 - CW))) >>> (61 - CW);
      hi = (longint'(1) <<< (CW - 1)) - 1;
      lo = -(longint'(1) <<< (CW - 1));
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[CW-1:0];
   endfunction

   function automatic longint mul_q30(input longint a, input longint b);
      return (a * b + (longint'(1) <<< 29)) >>> 30;
   endfunction

   // Expected rotation matrix for one angle triple.
   task automatic predict_matrix(input logic [AW-1:0] roll, input logic [AW-1:0] pitch,
                                 input logic [AW-1:0] yaw, output matrix_type m);
      longint cr, sr, cp, sp, cy, sy, srsp, crsp;
      angle_trig(roll, cr, sr);
      angle_trig(pitch, cp, sp);
      angle_trig(yaw, cy, sy);
      srsp = mul_q30(sr, sp);
      crsp = mul_q30(cr, sp);
      m.r00 = to_coef(cp * cy);
      m.r01 = to_coef(srsp * cy - cr * sy);
      m.r02 = to_coef(crsp * cy + sr * sy);
      m.r10 = to_coef(cp * sy);
      m.r11 = to_coef(srsp * sy + cr * cy);
      m.r12 = to_coef(crsp * sy - sr * cy);
      m.r20 = to_coef(-sp * (longint'(1) <<< 30));
      m.r21 = to_coef(sr * cp);
      m.r22 = to_coef(cr * cp);
   endtask

   // Print one mismatch line and count it.
   task automatic report_mismatch(input string line);
      error_count++;
      $display("mismatch %s", line);
   endtask

   task automatic check_entry(input string what, input logic signed [CW-1:0] got,
                              input logic signed [CW-1:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s: got %0d, expected %0d", what, got, want));
      end
   endtask

   // Send one request, idling beforehand at the current sender rate.
   task automatic send_angles(input logic [AW-1:0] roll, input logic [AW-1:0] pitch,
                              input logic [AW-1:0] yaw);
      matrix_type m;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      predict_matrix(roll, pitch, yaw, m);
      expected_matrices.push_back(m);
      req_bus.valid <= 1'b1;
      req_bus.roll_angle <= roll;
      req_bus.pitch_angle <= pitch;
      req_bus.yaw_angle <= yaw;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Withdraw the request and wait until every expected response has arrived.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (expected_matrices.size() != 0) @(negedge clock);
   endtask

   // Receiver readiness: random idling, or a long hold-off when requested.
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each accepted response with the oldest expected matrix.
   always @(posedge clock) begin
      matrix_type m;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_matrices.size() == 0) begin
            report_mismatch("response with nothing expected");
         end else begin
            m = expected_matrices.pop_front();
            check_entry("r00", rsp_bus.r00, m.r00);
            check_entry("r01", rsp_bus.r01, m.r01);
            check_entry("r02", rsp_bus.r02, m.r02);
            check_entry("r10", rsp_bus.r10, m.r10);
            check_entry("r11", rsp_bus.r11, m.r11);
            check_entry("r12", rsp_bus.r12, m.r12);
            check_entry("r20", rsp_bus.r20, m.r20);
            check_entry("r21", rsp_bus.r21, m.r21);
            check_entry("r22", rsp_bus.r22, m.r22);
         end
      end
   end

   // Extremes, right and eighth-turn angles, minus pi and zero on each axis, and mixed triples.
   task automatic test_special_angles();
      logic [AW-1:0] corner[8];
      corner = '{16'h0000, 16'h7FFF, 16'h8000, 16'h4000, 16'hC000, 16'h0001,
                 16'hFFFF, 16'h2000};
      foreach (corner[i]) send_angles(corner[i], corner[i], corner[i]);
      for (int i = 0; i < 8; i++) send_angles(corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8]);
      send_angles(16'h4000, 16'h4000, 16'h0000);
      send_angles(16'h8000, 16'hC000, 16'h7FFF);
      send_angles(16'h5555, 16'hAAAA, 16'h3FFF);
      wait_drained();
   endtask

   // Random angles, biased towards right angles and the edges of the range.
   task automatic test_random_angles(input int count);
      logic [AW-1:0] a[3];
      for (int n = 0; n < count; n++) begin
         foreach (a[k]) begin
            case ($urandom_range(3))
               0: a[k] = {2'($urandom_range(3)), (AW-2)'(0)}
                         + AW'($signed($urandom_range(4)) - 2);
               default: a[k] = AW'($urandom);
            endcase
         end
         send_angles(a[0], a[1], a[2]);
      end
   endtask

   // Receiver holds off long enough that the pipeline fills and stalls its input.
   task automatic test_back_pressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      wait_drained();
      hold_off_cycles = 3 * LATENCY;
      test_random_angles(60);
      wait_drained();
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.roll_angle = '0;
      req_bus.pitch_angle = '0;
      req_bus.yaw_angle = '0;
      rsp_bus.ready = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_special_angles();
      send_idle_pct = 34;
      recv_idle_pct = 59;
      test_random_angles(270);
      wait_drained();
      send_idle_pct = 59;
      recv_idle_pct = 34;
      test_random_angles(270);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_angles(200);
      test_back_pressure();

      wait_drained();
      repeat (2 * LATENCY) @(negedge clock);
      if (error_count == 0 && expected_matrices.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

### sim.f
design/eul_pkg.sv
design/eul_if.sv
design/eul_cordic_cell.sv
design/eul_matrix.sv
design/euler_to_rotation_matrix_unit.sv
dv/tb_top.sv
